[rtl/core/fkpc_pkg.sv]
// Shared types, constants and code helpers for the four-key press classifier.
`timescale 1ns / 1ps

package fkpc_pkg;

  localparam int unsigned NumKeys  = 4;
  localparam int unsigned PinW     = 4;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CodeW    = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned KeyIdxW  = $clog2(NumKeys);

  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounce   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPress  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgComboStart = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgComboExtra = 2'd3;

  // Register reset values
  localparam logic [CountW-1:0] DebounceRst   = 16'd2;
  localparam logic [CountW-1:0] LongPressRst  = 16'd100;
  localparam logic [CountW-1:0] ComboStartRst = 16'd0;
  localparam logic [CountW-1:0] ComboExtraRst = 16'd30;

  typedef logic [CodeW-1:0]   code_t;
  typedef logic [NumKeys-1:0] keyvec_t;

  typedef struct packed {
    logic [CountW-1:0] debounce;
    logic [CountW-1:0] long_press;
    logic [CountW-1:0] combo_start;
    logic [CountW-1:0] combo_extra;
  } cfg_t;

  // Next-state view of one key, before any combo fire is applied
  typedef struct packed {
    logic down_nxt;
    logic member_nxt;
    logic released;
    logic short_evt;
    logic long_evt;
  } key_evt_t;

  // Registered flags of one key
  typedef struct packed {
    logic down;
    logic locked;
    logic member;
    logic fired;
  } key_st_t;

  // Combo unit result for one transfer
  typedef struct packed {
    logic    fire;
    keyvec_t mask;
    code_t   code;
  } combo_res_t;

  function automatic code_t short_code(int unsigned idx);
    logic [31:0] v;
    v = idx + 32'd1;
    return v[CodeW-1:0];
  endfunction

  function automatic code_t long_code(int unsigned idx);
    logic [31:0] v;
    v = (idx + 32'd1) * 32'd11;
    return v[CodeW-1:0];
  endfunction

  function automatic code_t combo_code(logic [KeyIdxW-1:0] first,
                                       logic [KeyIdxW-1:0] second);
    logic [7:0] v;
    v = ({{(8-KeyIdxW){1'b0}}, first} + 8'd1) * 8'd10
        + {{(8-KeyIdxW){1'b0}}, second} + 8'd1;
    return v[CodeW-1:0];
  endfunction

endpackage

[rtl/core/fkpc_if.sv]
// Valid/ready channel interfaces for pin levels and key codes.
`timescale 1ns / 1ps

interface fkpc_pin_if;
  logic                       valid;
  logic                       ready;
  logic [fkpc_pkg::PinW-1:0]  pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface fkpc_code_if;
  logic                       valid;
  logic                       ready;
  logic [fkpc_pkg::CodeW-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

[rtl/core/fkpc_key_slice.sv]
// Per-key hold counter and flag state with short/long press detection.
`timescale 1ns / 1ps

module fkpc_key_slice (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               level_i,
  input  logic               mask_zero_i,
  input  logic               combo_set_i,
  input  fkpc_pkg::cfg_t     cfg_i,
  output fkpc_pkg::key_evt_t evt_o,
  output fkpc_pkg::key_st_t  st_o
);
  import fkpc_pkg::*;

  logic              down_q, down_d;
  logic              locked_q, locked_d;
  logic              member_q, member_d;
  logic              fired_q, fired_d;
  logic [CountW-1:0] hold_q, hold_d;
  logic [CountW-1:0] hold_base;

  always_comb begin
    down_d     = down_q;
    locked_d   = locked_q;
    member_d   = member_q;
    fired_d    = fired_q;
    hold_d     = hold_q;
    hold_base  = down_q ? hold_q : '0;
    evt_o      = '0;
    if (level_i) begin
      if (down_q) begin
        down_d = 1'b0;
        if (member_q) begin
          member_d = 1'b0;
          fired_d  = 1'b0;
        end else if (hold_q > cfg_i.debounce && hold_q <= cfg_i.long_press && mask_zero_i) begin
          evt_o.short_evt = 1'b1;
        end
        locked_d       = 1'b0;
        evt_o.released = 1'b1;
      end
      hold_d = '0;
    end else begin
      if (!down_q) begin
        down_d   = 1'b1;
        member_d = !mask_zero_i && !fired_q;
      end
      hold_d = (hold_base == CountMax) ? hold_base : hold_base + 1'b1;
      if (hold_d > cfg_i.long_press && !locked_q && mask_zero_i) begin
        evt_o.long_evt = 1'b1;
        locked_d       = 1'b1;
      end
    end
    evt_o.down_nxt   = down_d;
    evt_o.member_nxt = member_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q     <= 1'b0;
      locked_q   <= 1'b0;
      member_q   <= 1'b0;
      fired_q    <= 1'b0;
      hold_q     <= '0;
    end else if (accept_i) begin
      down_q     <= down_d;
      locked_q   <= locked_d | combo_set_i;
      member_q   <= member_d | combo_set_i;
      fired_q    <= fired_d | combo_set_i;
      hold_q     <= hold_d;
    end
  end

  assign st_o = '{down: down_q, locked: locked_q, member: member_q, fired: fired_q};

endmodule

[rtl/core/fkpc_combo.sv]
// Combo mask and combo timer; decides when a two-key combo code fires.
`timescale 1ns / 1ps

module fkpc_combo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  fkpc_pkg::keyvec_t    down_nxt_i,
  input  fkpc_pkg::keyvec_t    member_nxt_i,
  input  logic                 released_any_i,
  input  fkpc_pkg::cfg_t       cfg_i,
  output logic                 mask_zero_o,
  output fkpc_pkg::combo_res_t res_o
);
  import fkpc_pkg::*;

  keyvec_t           mask_q, mask_d, mask_a;
  logic [CountW-1:0] count_q, count_d, count_a, count_b;
  logic [CountW:0]   thresh;
  logic              multi;
  logic              got_first, got_second;
  logic [KeyIdxW-1:0] first_idx, second_idx;

  assign thresh      = {1'b0, cfg_i.debounce} + {1'b0, cfg_i.combo_extra};
  assign multi       = $countones(down_nxt_i) >= 2;
  assign mask_zero_o = (mask_q == '0);

  always_comb begin
    mask_a  = released_any_i ? member_nxt_i : mask_q;
    count_a = released_any_i ? cfg_i.combo_start : count_q;
    mask_d  = mask_a;
    count_b = count_a;
    if (multi) begin
      if (mask_a == '0) begin
        mask_d  = down_nxt_i;
        count_b = cfg_i.combo_start;
      end else if (count_a != CountMax) begin
        count_b = count_a + 1'b1;
      end
    end else begin
      mask_d  = '0;
      count_b = cfg_i.combo_start;
    end

    // two lowest keys of the mask
    got_first  = 1'b0;
    got_second = 1'b0;
    first_idx  = '0;
    second_idx = '0;
    for (int unsigned i = 0; i < NumKeys; i++) begin
      if (mask_d[i]) begin
        if (!got_first) begin
          got_first = 1'b1;
          first_idx = i[KeyIdxW-1:0];
        end else if (!got_second) begin
          got_second = 1'b1;
          second_idx = i[KeyIdxW-1:0];
        end
      end
    end

    res_o.fire = multi && ({1'b0, count_b} > thresh) && got_second;
    res_o.mask = mask_d;
    res_o.code = combo_code(first_idx, second_idx);
    count_d    = res_o.fire ? '0 : count_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      count_q <= ComboStartRst;
    end else if (accept_i) begin
      mask_q  <= mask_d;
      count_q <= count_d;
    end
  end

endmodule

[rtl/core/fkpc_out_buf.sv]
// Two-entry result buffer that decouples the code channel from the pin channel.
`timescale 1ns / 1ps

module fkpc_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fkpc_pkg::code_t     push_code_i,
  output logic                full_o,
  fkpc_code_if.source         out_if
);
  import fkpc_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  code_t      data0_q, data0_d;
  code_t      data1_q, data1_d;
  logic       pop;

  assign pop          = out_if.valid && out_if.ready;
  assign full_o       = cnt_q[1];
  assign out_if.valid = (cnt_q != 2'd0);
  assign out_if.key_code = data0_q;

  always_comb begin
    cnt_d   = cnt_q;
    data0_d = data0_q;
    data1_d = data1_q;
    case ({push_i, pop})
      2'b10: begin
        if (cnt_q == 2'd0) data0_d = push_code_i;
        else               data1_d = push_code_i;
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        data0_d = data1_q;
        cnt_d   = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          data0_d = push_code_i;
        end else begin
          data0_d = data1_q;
          data1_d = push_code_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data0_q <= data0_d;
    data1_q <= data1_d;
  end

endmodule

[rtl/core/four_key_press_classifier.sv]
// Top level of the four-key press classifier.
`timescale 1ns / 1ps
// Usage
//   in_if  : one transfer per scan tick; pin_levels bit i is key i+1, low = pressed.
//   out_if : exactly one key_code per accepted tick, in order. 0 means nothing;
//            1..4 short press, 11/22/33/44 long press, 12..34 two-key combo
//            (tens digit = lower key). Codes are not held across ticks.
//   cfg    : cfg_we_i writes cfg_data_i to register cfg_idx_i (0 debounce,
//            1 long press, 2 combo timer start, 3 combo extra ticks). Write only
//            while idle; takes effect for the next tick.
// Timing
//   Each tick is classified in a single pass of per-key compares/increments
//   and the combo timer, straight into the result buffer, which registers
//   key_code and its valid; throughput is one tick per cycle, limited only
//   by the two-entry result buffer.
// Reset
//   All key flags, hold counters and the combo mask clear; registers return to
//   2/100/0/30; combo timer loads 0. No clearing pass, ready from the first cycle.
// Backpressure
//   With out_if stalled the buffer still takes one more tick, then in_if.ready
//   drops until a code transfer frees a slot.

module four_key_press_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fkpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fkpc_pkg::CountW-1:0]    cfg_data_i,
  fkpc_pin_if.sink                       in_if,
  fkpc_code_if.source                    out_if
);
  import fkpc_pkg::*;

  cfg_t       cfg_q;
  logic       accept;
  logic       buf_full;
  logic       mask_zero;
  logic       released_any;
  keyvec_t    down_nxt, member_nxt;
  keyvec_t    down_vec, locked_vec, member_vec, fired_vec;
  key_evt_t   evt   [NumKeys];
  key_st_t    st    [NumKeys];
  combo_res_t combo;
  code_t      code;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce    <= DebounceRst;
      cfg_q.long_press  <= LongPressRst;
      cfg_q.combo_start <= ComboStartRst;
      cfg_q.combo_extra <= ComboExtraRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce:   cfg_q.debounce    <= cfg_data_i;
        CfgLongPress:  cfg_q.long_press  <= cfg_data_i;
        CfgComboStart: cfg_q.combo_start <= cfg_data_i;
        CfgComboExtra: cfg_q.combo_extra <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_if.ready = !buf_full;
  assign accept      = in_if.valid && in_if.ready;

  // One slice per key; keys beyond the pin width read as released
  for (genvar g = 0; g < NumKeys; g++) begin : g_key
    logic level;
    if (g < PinW) begin : g_pin
      assign level = in_if.pin_levels[g];
    end else begin : g_nopin
      assign level = 1'b1;
    end

    fkpc_key_slice u_slice (
      .clk_i,
      .rst_ni,
      .accept_i    (accept),
      .level_i     (level),
      .mask_zero_i (mask_zero),
      .combo_set_i (combo.fire && combo.mask[g]),
      .cfg_i       (cfg_q),
      .evt_o       (evt[g]),
      .st_o        (st[g])
    );

    assign down_nxt[g]   = evt[g].down_nxt;
    assign member_nxt[g] = evt[g].member_nxt;
    assign down_vec[g]   = st[g].down;
    assign locked_vec[g] = st[g].locked;
    assign member_vec[g] = st[g].member;
    assign fired_vec[g]  = st[g].fired;
  end

  always_comb begin
    released_any = 1'b0;
    for (int unsigned i = 0; i < NumKeys; i++) begin
      released_any = released_any | evt[i].released;
    end
  end

  fkpc_combo u_combo (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .down_nxt_i     (down_nxt),
    .member_nxt_i   (member_nxt),
    .released_any_i (released_any),
    .cfg_i          (cfg_q),
    .mask_zero_o    (mask_zero),
    .res_o          (combo)
  );

  // Later event wins: higher key over lower, combo over any key event
  always_comb begin
    code = '0;
    for (int unsigned i = 0; i < NumKeys; i++) begin
      if (evt[i].short_evt) code = short_code(i);
      if (evt[i].long_evt)  code = long_code(i);
    end
    if (combo.fire) code = combo.code;
  end

  fkpc_out_buf u_out_buf (
    .clk_i,
    .rst_ni,
    .push_i      (accept),
    .push_code_i (code),
    .full_o      (buf_full),
    .out_if      (out_if)
  );

  // Assertions

  // A firing combo locks every key of its mask
  a_fire_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && combo.fire |=> (($past(combo.mask) & ~locked_vec) == '0))
    else $error("combo fire did not lock its keys");

  // Key state only moves on a pin transfer
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(down_vec) && $stable(fired_vec))
    else $error("key state changed without a transfer");

  // A fired key stays down and in its combo until released
  a_fired_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fired_vec & ~(member_vec & down_vec)) == '0)
    else $error("fired key outside combo or released");

  // Input only stalls behind pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with no pending code");

endmodule
